FILE: src/cmvg_pkg.sv
package cmvg_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    localparam int SEG_W  = 11;
    localparam int IDX_W  = 13;
    localparam int GEO_W  = 16;
    localparam int I_W    = 11;
    localparam int CFG_IDX_W = 2;

    // pipelined divider: numerator, divisor, quotient
    localparam int NUM_W     = I_W + 16;
    localparam int DEN_W     = SEG_W + 1;
    localparam int DIV_STEPS = 17;
    localparam int DSH_W     = $clog2(DIV_STEPS);

    // CORDIC datapath, Q2.30 with headroom
    localparam int CW         = 34;
    localparam int FRAC_W     = 30;
    localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
    localparam int RS_W       = GEO_W + 2;
    localparam int PROD_W     = CW + RS_W;

    localparam logic [GEO_W-1:0] NORM_ONE = 16'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEGMENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;

    localparam logic signed [CW-1:0] ATAN_TAB [ATAN_LEN] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    typedef struct packed {
        logic rim;
        logic side;
        logic invalid;
    } vtx_tag_t;

    typedef struct packed {
        logic [NUM_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [DIV_STEPS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t ang;
        div_lane_t tu;
        vtx_tag_t  tag;
    } div_item_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
        logic [GEO_W-1:0]     tu;
        vtx_tag_t             tag;
    } cordic_item_t;

    typedef struct packed {
        logic [GEO_W-1:0] hn;
        logic [GEO_W-1:0] rn;
        logic [GEO_W-1:0] tv_rim;
        logic             busy;
    } cfgu_status_t;

    typedef enum logic [3:0] {
        CFGU_SQ_H,
        CFGU_SQ_R,
        CFGU_ROOT,
        CFGU_LD_H,
        CFGU_DIV_H,
        CFGU_LD_R,
        CFGU_DIV_R,
        CFGU_LD_V,
        CFGU_DIV_V,
        CFGU_DONE
    } cfgu_state_t;

endpackage

FILE: src/cmvg_div_cell.sv
module cmvg_div_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [cmvg_pkg::DSH_W-1:0] shift,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cmvg_pkg::div_item_t        in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cmvg_pkg::div_item_t        out_item
);
    import cmvg_pkg::*;

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    // one restoring step: try the divisor at this cell's bit weight
    function automatic div_lane_t div_step(input div_lane_t l, input logic [DSH_W-1:0] sh);
        logic [NUM_W:0] part;
        logic [NUM_W:0] ext;
        div_lane_t      res;
        res  = l;
        part = {{(NUM_W + 1 - DEN_W){1'b0}}, l.den} << sh;
        ext  = {1'b0, l.rem};
        if (ext >= part) begin
            res.rem     = NUM_W'(ext - part);
            res.quo[sh] = 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        item_next     = in_item;
        item_next.ang = div_step(in_item.ang, shift);
        item_next.tu  = div_step(in_item.tu, shift);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/cmvg_cordic_cell.sv
module cmvg_cordic_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cmvg_pkg::ATAN_IDX_W-1:0] step,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cmvg_pkg::cordic_item_t          in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cmvg_pkg::cordic_item_t          out_item
);
    import cmvg_pkg::*;

    logic                 valid_reg;
    cordic_item_t         item_reg;
    cordic_item_t         item_next;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;

    // rotate towards z = 0 by the arctangent of this step
    always_comb begin
        x         = in_item.x;
        y         = in_item.y;
        z         = in_item.z;
        item_next = in_item;
        if (z >= 0) begin
            item_next.x = x - (y >>> step);
            item_next.y = y + (x >>> step);
            item_next.z = z - ATAN_TAB[step];
        end else begin
            item_next.x = x + (y >>> step);
            item_next.y = y - (x >>> step);
            item_next.z = z + ATAN_TAB[step];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/cmvg_cfg_unit.sv
module cmvg_cfg_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [cmvg_pkg::GEO_W-1:0] radius,
    input  logic [cmvg_pkg::GEO_W-1:0] cone_height,
    output cmvg_pkg::cfgu_status_t     status
);
    import cmvg_pkg::*;

    localparam int ROOT_STEPS = 32;
    localparam int DIVC_STEPS = 16;
    localparam int CNT_W      = 5;
    localparam int WIDE_W     = 64;
    localparam int NRM_SHIFT  = 28;
    localparam int TEX_SHIFT  = 15;

    cfgu_state_t         state_reg;
    cfgu_state_t         state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WIDE_W-1:0]   acc_reg;
    logic [WIDE_W-1:0]   bit_reg;
    logic [WIDE_W-1:0]   res_reg;
    logic [GEO_W-1:0]    quo_reg;
    logic                zero_reg;
    logic [GEO_W-1:0]    hn_reg;
    logic [GEO_W-1:0]    rn_reg;
    logic [GEO_W-1:0]    tv_reg;

    logic [2*GEO_W-1:0]  sq_h;
    logic [2*GEO_W-1:0]  sq_r;
    logic [WIDE_W-1:0]   root_try;
    logic                root_take;
    logic                div_take;
    logic [GEO_W-1:0]    quo_next;
    logic [GEO_W-1:0]    q_sat;
    logic [GEO_W:0]      sum_rh;
    logic                last_root;
    logic                last_div;

    assign sq_h      = cone_height * cone_height;
    assign sq_r      = radius * radius;
    assign root_try  = res_reg + bit_reg;
    assign root_take = acc_reg >= root_try;
    assign div_take  = acc_reg >= bit_reg;
    assign quo_next  = {quo_reg[GEO_W-2:0], div_take};
    assign q_sat     = (quo_next > NORM_ONE) ? NORM_ONE : quo_next;
    assign sum_rh    = {1'b0, radius} + {1'b0, cone_height};
    assign last_root = cnt_reg == CNT_W'(ROOT_STEPS - 1);
    assign last_div  = cnt_reg == CNT_W'(DIVC_STEPS - 1);

    always_comb begin
        state_next = state_reg;
        if (start) begin
            state_next = CFGU_SQ_H;
        end else begin
            unique case (state_reg)
                CFGU_SQ_H:  state_next = CFGU_SQ_R;
                CFGU_SQ_R:  state_next = CFGU_ROOT;
                CFGU_ROOT:  if (last_root) state_next = CFGU_LD_H;
                CFGU_LD_H:  state_next = CFGU_DIV_H;
                CFGU_DIV_H: if (last_div) state_next = CFGU_LD_R;
                CFGU_LD_R:  state_next = CFGU_DIV_R;
                CFGU_DIV_R: if (last_div) state_next = CFGU_LD_V;
                CFGU_LD_V:  state_next = CFGU_DIV_V;
                CFGU_DIV_V: if (last_div) state_next = CFGU_DONE;
                CFGU_DONE:  state_next = CFGU_DONE;
                default:    state_next = CFGU_DONE;
            endcase
        end
    end

    always_comb begin
        status.busy   = state_reg != CFGU_DONE;
        status.hn     = hn_reg;
        status.rn     = rn_reg;
        status.tv_rim = tv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CFGU_SQ_H;
        end else begin
            state_reg <= state_next;
        end
    end

    // square sum, bit-pair square root, then three restoring divisions
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            CFGU_SQ_H: begin
                acc_reg <= WIDE_W'(sq_h);
            end
            CFGU_SQ_R: begin
                acc_reg <= (acc_reg + WIDE_W'(sq_r)) << NRM_SHIFT;
                res_reg <= '0;
                bit_reg <= WIDE_W'(1) << (WIDE_W - 2);
                cnt_reg <= '0;
            end
            CFGU_ROOT: begin
                if (root_take) begin
                    acc_reg <= acc_reg - root_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            CFGU_LD_H, CFGU_LD_R: begin
                zero_reg <= res_reg == '0;
                if (state_reg == CFGU_LD_H) begin
                    acc_reg <= (WIDE_W'(cone_height) << NRM_SHIFT) + (res_reg >> 1);
                end else begin
                    acc_reg <= (WIDE_W'(radius) << NRM_SHIFT) + (res_reg >> 1);
                end
                bit_reg <= res_reg << (DIVC_STEPS - 1);
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            CFGU_LD_V: begin
                zero_reg <= sum_rh == '0;
                acc_reg  <= (WIDE_W'(radius) << TEX_SHIFT) + WIDE_W'(sum_rh >> 1);
                bit_reg  <= WIDE_W'(sum_rh) << (DIVC_STEPS - 1);
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            CFGU_DIV_H, CFGU_DIV_R, CFGU_DIV_V: begin
                if (div_take) begin
                    acc_reg <= acc_reg - bit_reg;
                end
                bit_reg <= bit_reg >> 1;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_div) begin
                    if (state_reg == CFGU_DIV_H) begin
                        hn_reg <= zero_reg ? '0 : q_sat;
                    end else if (state_reg == CFGU_DIV_R) begin
                        rn_reg <= zero_reg ? '0 : q_sat;
                    end else begin
                        tv_reg <= zero_reg ? '0 : quo_next;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/cone_mesh_vertex_generator.sv
// Cone mesh vertex generator. Each input transaction carries one vertex index
// and yields one output transaction with that vertex's Q8.8 position, Q2.14
// normal and Q1.15 texture coordinate, or index_invalid with all other fields
// zero when the index lies beyond 4*segments+1. The datapath is a chain of
// cells: a decode stage, 17 divider cells (angle and u in parallel), an angle
// fold stage, 16 CORDIC cells, a multiply stage and the output register, and
// one vertex is accepted every cycle while s_ready is high; each cell holds
// its transaction only while the next one is full, so bubbles close up and a
// waiting result stops input only once every cell is full.
// The slant normal components and the rim v coordinate depend on radius and
// height alone and are worked out by a sequential unit (square sum, 32-step
// square root, three 16-step divisions) that runs after reset and after every
// configuration write, during which s_ready stays low. Write
// configuration only while the block is empty.
module cone_mesh_vertex_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cmvg_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cmvg_pkg::GEO_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cmvg_pkg::IDX_W-1:0]     s_vertex_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_pos_x,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_pos_y,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_pos_z,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_norm_x,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_norm_y,
    output logic signed [cmvg_pkg::GEO_W-1:0] m_norm_z,
    output logic [cmvg_pkg::GEO_W-1:0]     m_tex_u,
    output logic [cmvg_pkg::GEO_W-1:0]     m_tex_v,
    output logic                           m_index_invalid
);
    import cmvg_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] pz;
        logic signed [PROD_W-1:0] nx;
        logic signed [PROD_W-1:0] nz;
        logic [GEO_W-1:0]         tu;
        vtx_tag_t                 tag;
    } prod_item_t;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [GEO_W:0]    POS_LO   = -17'sd32768;
    localparam logic signed [GEO_W:0]    POS_HI   = 17'sd32767;
    localparam logic signed [GEO_W:0]    NRM_LO   = -17'sd16384;
    localparam logic signed [GEO_W:0]    NRM_HI   = 17'sd16384;
    localparam logic [GEO_W-1:0]         NY_DOWN  = 16'hC000;
    localparam logic [GEO_W-1:0]         TV_FULL  = 16'h8000;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SEG_W-1:0] segments_reg;
    logic [GEO_W-1:0] radius_reg;
    logic [GEO_W-1:0] cone_height_reg;
    logic [SEG_W-1:0] seg_eff;
    cfgu_status_t     cfg_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segments_reg    <= SEG_W'(16);
            radius_reg      <= GEO_W'(256);
            cone_height_reg <= GEO_W'(512);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_IDX_SEGMENTS: segments_reg    <= cfg_wdata[SEG_W-1:0];
                CFG_IDX_RADIUS:   radius_reg      <= cfg_wdata;
                CFG_IDX_HEIGHT:   cone_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Restart the slant-normal unit on every write; it also runs out of reset.
    cmvg_cfg_unit u_cfg_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cfg_we),
        .radius      (radius_reg),
        .cone_height (cone_height_reg),
        .status      (cfg_status)
    );

    // Clamp the segment count: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (segments_reg == '0) begin
            seg_eff = SEG_W'(1);
        end else if (segments_reg > SEG_W'(MAX_SEGMENTS)) begin
            seg_eff = SEG_W'(MAX_SEGMENTS);
        end else begin
            seg_eff = segments_reg;
        end
    end

    // ------------------------------------------------------------------
    // Decode stage: side/base, rim/apex, and the two division operands
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] lim4;
    logic [IDX_W-1:0] lim2;
    logic [IDX_W-1:0] dec_m;
    logic [I_W-1:0]   dec_i;
    div_item_t        dec_item;
    logic             d_valid_reg;
    div_item_t        d_item_reg;
    logic             d_ready;

    logic             div_v [DIV_STEPS+1];
    logic             div_r [DIV_STEPS+1];
    div_item_t        div_d [DIV_STEPS+1];

    always_comb begin
        lim4               = {seg_eff, 2'b00} + IDX_W'(1);
        lim2               = {1'b0, seg_eff, 1'b0};
        dec_item.tag.invalid = s_vertex_index > lim4;
        dec_item.tag.side  = s_vertex_index <= lim2;
        dec_m              = dec_item.tag.side ? s_vertex_index
                                               : s_vertex_index - lim2 - IDX_W'(1);
        dec_i              = dec_m[I_W:1];
        dec_item.tag.rim   = !dec_m[0];
        // angle = i * 2^16 / S in 2^-16 turns
        dec_item.ang.rem   = {dec_i, 16'b0};
        dec_item.ang.den   = DEN_W'(seg_eff);
        dec_item.ang.quo   = '0;
        // u: round(i/S) for a rim point, round((2i+1)/(2S)) for apex and centre
        if (dec_item.tag.rim) begin
            dec_item.tu.rem = NUM_W'({dec_i, 15'b0}) + NUM_W'(seg_eff >> 1);
            dec_item.tu.den = DEN_W'(seg_eff);
        end else begin
            dec_item.tu.rem = {dec_i, 1'b1, 15'b0} + NUM_W'(seg_eff);
            dec_item.tu.den = {seg_eff, 1'b0};
        end
        dec_item.tu.quo    = '0;
    end

    // Hold input back while the slant-normal unit is busy.
    assign d_ready = !d_valid_reg || div_r[0];
    assign s_ready = d_ready && !cfg_status.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= s_valid && !cfg_status.busy;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            d_item_reg <= dec_item;
        end
    end

    assign div_v[0] = d_valid_reg;
    assign div_d[0] = d_item_reg;

    // ------------------------------------------------------------------
    // Divider cells: one quotient bit per cell, most significant first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        cmvg_div_cell u_div_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (DSH_W'(DIV_STEPS - 1 - k)),
            .in_valid  (div_v[k]),
            .in_ready  (div_r[k]),
            .in_item   (div_d[k]),
            .out_valid (div_v[k+1]),
            .out_ready (div_r[k+1]),
            .out_item  (div_d[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Angle fold stage: reduce to a quarter turn either side of zero and
    // convert to Q2.30 radians, truncating towards zero
    // ------------------------------------------------------------------
    logic                 cor_v [CORDIC_STEPS+1];
    logic                 cor_r [CORDIC_STEPS+1];
    cordic_item_t         cor_d [CORDIC_STEPS+1];

    logic [GEO_W-1:0]          ang;
    logic signed [GEO_W-1:0]   red;
    logic signed [GEO_W+CW-1:0] zprod;
    logic signed [GEO_W+CW-1:0] zbias;
    cordic_item_t              fold_item;
    logic                      p_valid_reg;
    cordic_item_t              p_item_reg;

    always_comb begin
        ang           = div_d[DIV_STEPS].ang.quo[GEO_W-1:0];
        fold_item.neg = ang[GEO_W-1] ^ ang[GEO_W-2];
        red           = fold_item.neg ? $signed({~ang[GEO_W-1], ang[GEO_W-2:0]})
                                      : $signed(ang);
        zprod         = red * TWO_PI_Q30;
        zbias         = zprod + (zprod[GEO_W+CW-1] ? (GEO_W+CW)'(65535) : '0);
        fold_item.z   = CW'(zbias >>> 16);
        fold_item.x   = CORDIC_GAIN;
        fold_item.y   = '0;
        fold_item.tu  = div_d[DIV_STEPS].tu.quo[GEO_W-1:0];
        fold_item.tag = div_d[DIV_STEPS].tag;
    end

    assign div_r[DIV_STEPS] = !p_valid_reg || cor_r[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (div_r[DIV_STEPS]) begin
            p_valid_reg <= div_v[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (div_r[DIV_STEPS] && div_v[DIV_STEPS]) begin
            p_item_reg <= fold_item;
        end
    end

    assign cor_v[0] = p_valid_reg;
    assign cor_d[0] = p_item_reg;

    // ------------------------------------------------------------------
    // CORDIC cells: one rotation each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        cmvg_cordic_cell u_cordic_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (ATAN_IDX_W'(k)),
            .in_valid  (cor_v[k]),
            .in_ready  (cor_r[k]),
            .in_item   (cor_d[k]),
            .out_valid (cor_v[k+1]),
            .out_ready (cor_r[k+1]),
            .out_item  (cor_d[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Multiply stage: the half-turn sign flip is folded into the narrow
    // operand so each product is a single 34 x 18 multiply
    // ------------------------------------------------------------------
    logic signed [RS_W-1:0] r_mag;
    logic signed [RS_W-1:0] h_mag;
    logic signed [RS_W-1:0] r_s;
    logic signed [RS_W-1:0] h_s;
    prod_item_t             mul_item;
    logic                   x_valid_reg;
    prod_item_t             x_item_reg;
    logic                   x_ready;
    logic                   o_ready;

    always_comb begin
        r_mag        = $signed({2'b00, radius_reg});
        h_mag        = $signed({2'b00, cfg_status.hn});
        r_s          = cor_d[CORDIC_STEPS].neg ? -r_mag : r_mag;
        h_s          = cor_d[CORDIC_STEPS].neg ? -h_mag : h_mag;
        mul_item.px  = cor_d[CORDIC_STEPS].x * r_s;
        mul_item.pz  = cor_d[CORDIC_STEPS].y * r_s;
        mul_item.nx  = cor_d[CORDIC_STEPS].x * h_s;
        mul_item.nz  = cor_d[CORDIC_STEPS].y * h_s;
        mul_item.tu  = cor_d[CORDIC_STEPS].tu;
        mul_item.tag = cor_d[CORDIC_STEPS].tag;
    end

    assign x_ready             = !x_valid_reg || o_ready;
    assign cor_r[CORDIC_STEPS] = x_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
        end else if (x_ready) begin
            x_valid_reg <= cor_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (x_ready && cor_v[CORDIC_STEPS]) begin
            x_item_reg <= mul_item;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round half up from Q30, saturate, select per vertex kind
    // ------------------------------------------------------------------
    function automatic logic [GEO_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p,
                                                 input logic signed [GEO_W:0] lo,
                                                 input logic signed [GEO_W:0] hi);
        logic signed [PROD_W-1:0] q;
        q = (p + RND_HALF) >>> FRAC_W;
        if (q < lo) begin
            return GEO_W'(lo);
        end else if (q > hi) begin
            return GEO_W'(hi);
        end
        return GEO_W'(q);
    endfunction

    logic             o_valid_reg;
    logic [GEO_W-1:0] o_px_reg, o_py_reg, o_pz_reg;
    logic [GEO_W-1:0] o_nx_reg, o_ny_reg, o_nz_reg;
    logic [GEO_W-1:0] o_tu_reg, o_tv_reg;
    logic             o_inv_reg;
    logic [GEO_W-1:0] o_px_next, o_py_next, o_pz_next;
    logic [GEO_W-1:0] o_nx_next, o_ny_next, o_nz_next;
    logic [GEO_W-1:0] o_tu_next, o_tv_next;
    logic [GEO_W-1:0] h2;
    logic [GEO_W-1:0] neg_h2;

    assign h2     = cone_height_reg >> 1;
    assign neg_h2 = GEO_W'(0) - h2;

    always_comb begin
        o_px_next = '0;
        o_pz_next = '0;
        o_py_next = '0;
        o_nx_next = '0;
        o_ny_next = '0;
        o_nz_next = '0;
        o_tu_next = '0;
        o_tv_next = '0;
        if (!x_item_reg.tag.invalid) begin
            o_tu_next = x_item_reg.tu;
            if (x_item_reg.tag.rim) begin
                o_px_next = rnd_sat(x_item_reg.px, POS_LO, POS_HI);
                o_pz_next = rnd_sat(x_item_reg.pz, POS_LO, POS_HI);
                o_py_next = neg_h2;
                o_tv_next = cfg_status.tv_rim;
            end else begin
                // apex sits on top; base centre below with v at full scale
                o_py_next = x_item_reg.tag.side ? h2 : neg_h2;
                o_tv_next = x_item_reg.tag.side ? '0 : TV_FULL;
            end
            if (x_item_reg.tag.side) begin
                o_nx_next = rnd_sat(x_item_reg.nx, NRM_LO, NRM_HI);
                o_nz_next = rnd_sat(x_item_reg.nz, NRM_LO, NRM_HI);
                o_ny_next = cfg_status.rn;
            end else begin
                o_ny_next = NY_DOWN;
            end
        end
    end

    assign o_ready = !o_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= x_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready && x_valid_reg) begin
            o_px_reg  <= o_px_next;
            o_py_reg  <= o_py_next;
            o_pz_reg  <= o_pz_next;
            o_nx_reg  <= o_nx_next;
            o_ny_reg  <= o_ny_next;
            o_nz_reg  <= o_nz_next;
            o_tu_reg  <= o_tu_next;
            o_tv_reg  <= o_tv_next;
            o_inv_reg <= x_item_reg.tag.invalid;
        end
    end

    assign m_valid         = o_valid_reg;
    assign m_pos_x         = $signed(o_px_reg);
    assign m_pos_y         = $signed(o_py_reg);
    assign m_pos_z         = $signed(o_pz_reg);
    assign m_norm_x        = $signed(o_nx_reg);
    assign m_norm_y        = $signed(o_ny_reg);
    assign m_norm_z        = $signed(o_nz_reg);
    assign m_tex_u         = o_tu_reg;
    assign m_tex_v         = o_tv_reg;
    assign m_index_invalid = o_inv_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_status.busy |-> !s_ready)
        else $error("input taken while slant normal unit busy");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_index_invalid) |-> (m_pos_x == '0 && m_pos_y == '0 &&
            m_pos_z == '0 && m_norm_x == '0 && m_norm_y == '0 && m_norm_z == '0 &&
            m_tex_u == '0 && m_tex_v == '0))
        else $error("invalid index with non-zero fields");

    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_norm_x >= -16'sd16384 && m_norm_x <= 16'sd16384 &&
            m_norm_z >= -16'sd16384 && m_norm_z <= 16'sd16384))
        else $error("normal component out of range");

    a_slant_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(cfg_status.busy) |-> (cfg_status.hn <= NORM_ONE && cfg_status.rn <= NORM_ONE))
        else $error("slant normal exceeds unit length");

endmodule

FILE: bench/cone_vertex_checker.sv
module cone_vertex_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cmvg_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cmvg_pkg::GEO_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [cmvg_pkg::IDX_W-1:0]     s_vertex_index,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_pos_x,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_pos_y,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_pos_z,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_norm_x,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_norm_y,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_norm_z,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_tex_u,
    input  logic [cmvg_pkg::GEO_W-1:0]     m_tex_v,
    input  logic                           m_index_invalid,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cmvg_pkg::*;

    typedef struct {
        logic [15:0] f [9];
    } vertex_t;

    vertex_t vertex_q [$];
    logic [10:0] seg_reg;
    logic [15:0] rad_reg;
    logic [15:0] hgt_reg;

    function automatic longint fshift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint rshift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // rotate the gain vector through angle a (2^-16 turns), folded to +-1/4
    function automatic void rotate(input int unsigned a, output longint c, output longint s);
        longint x, y, z, xn, red;
        bit neg;
        x = 652032874;
        y = 0;
        neg = 0;
        a &= 32'hFFFF;
        if (a < 16384) red = a;
        else if (a < 49152) begin
            red = longint'(a) - 32768;
            neg = 1;
        end else red = longint'(a) - 65536;
        z = (red * 64'sd6746518852) / 65536;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (z >= 0) begin
                xn = x - fshift(y, k);
                y = y + fshift(x, k);
                z -= ATAN_TAB[k];
            end else begin
                xn = x + fshift(y, k);
                y = y - fshift(x, k);
                z += ATAN_TAB[k];
            end
            x = xn;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic vertex_t build_vertex(logic [12:0] vi);
        vertex_t v;
        longint unsigned s, n, i, m, r, h, h2, len, sum;
        longint px, py, pz, nx, ny, nz, tu, tv, c, sn, hn, rn;
        bit side, rim;
        s = seg_reg;
        if (s == 0) s = 1;
        if (s > MAX_SEGMENTS) s = MAX_SEGMENTS;
        r = rad_reg;
        h = hgt_reg;
        n = vi;
        px = 0; py = 0; pz = 0; nx = 0; ny = 0; nz = 0; tu = 0; tv = 0; hn = 0; rn = 0;
        foreach (v.f[j]) v.f[j] = '0;
        if (n > 4 * s + 1) begin
            v.f[8] = 1;
            return v;
        end
        side = n <= 2 * s;
        m = side ? n : n - (2 * s + 1);
        i = m >> 1;
        rim = m[0] == 0;
        h2 = h >> 1;
        rotate(int'((i << 16) / s), c, sn);
        if (rim) begin
            px = clampv(rshift(c * longint'(r), 30), -32768, 32767);
            pz = clampv(rshift(sn * longint'(r), 30), -32768, 32767);
            py = -longint'(h2);
            tu = (i * 32768 + s / 2) / s;
            sum = r + h;
            tv = sum != 0 ? (r * 32768 + sum / 2) / sum : 0;
        end else begin
            py = side ? longint'(h2) : -longint'(h2);
            tu = ((2 * i + 1) * 32768 + s) / (2 * s);
            tv = side ? 0 : 32768;
        end
        if (side) begin
            len = root64((h * h + r * r) << 28);
            if (len != 0) begin
                hn = ((h << 28) + len / 2) / len;
                rn = ((r << 28) + len / 2) / len;
                if (hn > 16384) hn = 16384;
                if (rn > 16384) rn = 16384;
            end
            nx = clampv(rshift(c * hn, 30), -16384, 16384);
            nz = clampv(rshift(sn * hn, 30), -16384, 16384);
            ny = rn;
        end else begin
            ny = -16384;
        end
        v.f[0] = px[15:0]; v.f[1] = py[15:0]; v.f[2] = pz[15:0];
        v.f[3] = nx[15:0]; v.f[4] = ny[15:0]; v.f[5] = nz[15:0];
        v.f[6] = tu[15:0]; v.f[7] = tv[15:0];
        return v;
    endfunction

    string field_name [9] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y", "norm_z",
                              "tex_u", "tex_v", "index_invalid"};

    assign pending = vertex_q.size();

    always @(posedge aclk) begin
        vertex_t want;
        logic [15:0] got [9];
        int errs;
        errs = 0;
        if (!aresetn) begin
            seg_reg <= 11'd16;
            rad_reg <= 16'd256;
            hgt_reg <= 16'd512;
            vertex_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_IDX_SEGMENTS: seg_reg <= cfg_wdata[10:0];
                    CFG_IDX_RADIUS:   rad_reg <= cfg_wdata;
                    CFG_IDX_HEIGHT:   hgt_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) vertex_q.push_back(build_vertex(s_vertex_index));
            if (m_valid && m_ready) begin
                got = '{m_pos_x, m_pos_y, m_pos_z, m_norm_x, m_norm_y, m_norm_z,
                        m_tex_u, m_tex_v, {15'd0, m_index_invalid}};
                if (vertex_q.size() == 0) begin
                    $error("unexpected vertex on output");
                    errs++;
                end else begin
                    want = vertex_q.pop_front();
                    for (int j = 0; j < 9; j++)
                        if (got[j] !== want.f[j]) begin
                            $error("%s: expected %0d, got %0d", field_name[j],
                                   want.f[j], got[j]);
                            errs++;
                        end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmvg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk, aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [GEO_W-1:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [IDX_W-1:0] s_vertex_index;
    logic [GEO_W-1:0] m_pos_x, m_pos_y, m_pos_z, m_norm_x, m_norm_y, m_norm_z;
    logic [GEO_W-1:0] m_tex_u, m_tex_v;
    logic m_index_invalid;
    int fail_count, pending;
    int cycle_count;
    int unsigned cur_segs;

    cone_mesh_vertex_generator dut (.*);

    cone_vertex_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // give up if the run hangs
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // random gap length: mostly short, now and then long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stalls at random, with idle-free stretches
    initial begin
        int g;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            g = 0;
            if ($urandom_range(0, 7) == 0) g = gap_len();
            if (g != 0) begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    // write one register; the caller drops the write enable afterwards
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GEO_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_IDX_SEGMENTS) begin
            cur_segs = val[10:0];
            if (cur_segs == 0) cur_segs = 1;
            if (cur_segs > MAX_SEGMENTS) cur_segs = MAX_SEGMENTS;
        end
    endtask

    task automatic write_all(logic [GEO_W-1:0] seg, logic [GEO_W-1:0] rad,
                             logic [GEO_W-1:0] hgt);
        write_reg(CFG_IDX_SEGMENTS, seg);
        write_reg(CFG_IDX_RADIUS, rad);
        write_reg(CFG_IDX_HEIGHT, hgt);
        cfg_we <= 0;
    endtask

    // present one vertex index and hold it until it is accepted
    task automatic send_vertex(logic [IDX_W-1:0] vi);
        int g;
        s_valid <= 1;
        s_vertex_index <= vi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = ($urandom_range(0, 3) != 0) ? gap_len() : 0;
        if (g != 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // drain the pipe before any register write
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // mostly in-range indices, with a share just past the end and wild ones
    function automatic logic [IDX_W-1:0] pick_index();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) return IDX_W'($urandom_range(0, 4 * cur_segs + 1));
        if (p < 90) return IDX_W'(4 * cur_segs + 1 + $urandom_range(1, 3));
        return IDX_W'($urandom_range(0, 8191));
    endfunction

    task automatic config_phase(int seg, int rad, int hgt, int count);
        drain();
        write_all(GEO_W'(seg), GEO_W'(rad), GEO_W'(hgt));
        for (int k = 0; k < count; k++) send_vertex(pick_index());
    endtask

    initial begin
        cfg_we = 0;
        cfg_idx = CFG_IDX_SEGMENTS;
        cfg_wdata = '0;
        s_valid = 0;
        s_vertex_index = '0;
        cur_segs = 16;
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset settings: both side ends, apex, base rim, centre, last, out of range
        send_vertex(IDX_W'(0));
        send_vertex(IDX_W'(1));
        send_vertex(IDX_W'(2));
        send_vertex(IDX_W'(8));
        send_vertex(IDX_W'(32));
        send_vertex(IDX_W'(33));
        send_vertex(IDX_W'(34));
        send_vertex(IDX_W'(64));
        send_vertex(IDX_W'(65));
        send_vertex(IDX_W'(66));
        send_vertex(IDX_W'(8191));
        send_vertex(IDX_W'(4097));

        // zero segments treated as one; zero radius and height
        drain();
        write_all(16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 7; k++) send_vertex(IDX_W'(k));

        // widest ring, largest geometry: saturation and top index
        drain();
        write_all(16'h07FF, 16'hFFFF, 16'hFFFF);
        send_vertex(IDX_W'(0));
        send_vertex(IDX_W'(2 * 512));
        send_vertex(IDX_W'(4097));
        send_vertex(IDX_W'(4098));
        send_vertex(IDX_W'(4096));

        config_phase(1024, 65535, 0, 60);
        config_phase(3, 0, 65535, 60);
        config_phase(16, 256, 512, 80);
        repeat (6)
            config_phase($urandom_range(1, 2047), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), 50);

        drain();
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
